// ===== design/tlct_pkg.sv =====
// ----------------------------------------------------------------------------
// tlct_pkg
// Shared constants, types and helpers for the tagged loop counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package tlct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 16;
    localparam int FIELD_KEY_W   = 16;
    localparam int SKEY_W        = (KEY_BITS < FIELD_KEY_W) ? KEY_BITS : FIELD_KEY_W;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int DEPTH_W       = 8;
    localparam int COUNT_W       = 32;
    localparam int MODE_W        = 2;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_REPEAT     = 2'd0;
    localparam t_mode MODE_CLEAR_ONE  = 2'd1;
    localparam t_mode MODE_CLEAR_FROM = 2'd2;
    localparam t_mode MODE_CLEAR_ALL  = 2'd3;

    // query word walking down the cell row
    typedef struct packed {
        logic                       vld;
        t_mode                      mode;
        logic [SKEY_W-1:0]          key;
        logic [DEPTH_W-1:0]         depth;
        logic signed [COUNT_W-1:0]  times;
        logic                       hit;
        logic                       enter;
        logic                       have_empty;
        logic [IDX_W-1:0]           empty_idx;
    } t_query;

    // slot claim broadcast to every cell
    typedef struct packed {
        logic                       vld;
        logic [IDX_W-1:0]           idx;
        logic [SKEY_W-1:0]          key;
        logic [DEPTH_W-1:0]         depth;
        logic signed [COUNT_W-1:0]  count;
    } t_commit;

    // decrement by one, floor at the most negative count
    function automatic logic signed [COUNT_W-1:0] sat_dec(
        input logic signed [COUNT_W-1:0] v
    );
        logic signed [COUNT_W-1:0] floor_v;
        floor_v = {1'b1, {(COUNT_W-1){1'b0}}};
        return (v == floor_v) ? v : v - COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== design/tlct_in_if.sv =====
// ----------------------------------------------------------------------------
// tlct_in_if
// Request word channel: mode, key, nesting depth and repeat count.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlct_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] key;
    logic [7:0]  nest_depth;
    logic signed [31:0] times;

    modport source (output valid, mode, key, nest_depth, times, input ready);
    modport sink   (input valid, mode, key, nest_depth, times, output ready);
endinterface

`default_nettype wire

// ===== design/tlct_out_if.sv =====
// ----------------------------------------------------------------------------
// tlct_out_if
// Result word channel: enter, found and table full flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlct_out_if;
    logic valid;
    logic ready;
    logic enter;
    logic found;
    logic table_full;

    modport source (output valid, enter, found, table_full, input ready);
    modport sink   (input valid, enter, found, table_full, output ready);
endinterface

`default_nettype wire

// ===== design/tlct_cell.sv =====
// ----------------------------------------------------------------------------
// tlct_cell
// One table slot. Checks the passing query against its tag, updates or
// clears itself, and forwards the query, registered, to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tlct_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [tlct_pkg::IDX_W-1:0]  i_idx,
    input  wire tlct_pkg::t_query            i_q,
    input  wire tlct_pkg::t_commit           i_wr,
    output tlct_pkg::t_query                 o_q
);

    logic [tlct_pkg::SKEY_W-1:0]         r_key,   n_key;
    logic [tlct_pkg::DEPTH_W-1:0]        r_depth, n_depth;
    logic signed [tlct_pkg::COUNT_W-1:0] r_cnt,   n_cnt;
    tlct_pkg::t_query                    r_q,     n_q;

    logic                                match;
    logic                                empty;
    logic signed [tlct_pkg::COUNT_W-1:0] dec;

    always_comb begin
        n_key   = r_key;
        n_depth = r_depth;
        n_cnt   = r_cnt;
        n_q     = i_q;
        match   = (i_q.key != '0) && (r_key == i_q.key) && (r_depth == i_q.depth);
        empty   = (r_key == '0);
        dec     = tlct_pkg::sat_dec(r_cnt);
        if (i_q.vld) begin
            case (i_q.mode)
                tlct_pkg::MODE_REPEAT: begin
                    if (match) begin
                        n_cnt     = dec;
                        n_q.hit   = 1'b1;
                        n_q.enter = !dec[tlct_pkg::COUNT_W-1];
                    end
                    if (empty && !i_q.have_empty) begin
                        n_q.have_empty = 1'b1;
                        n_q.empty_idx  = i_idx;
                    end
                end
                tlct_pkg::MODE_CLEAR_ONE: begin
                    if (match) begin
                        n_key   = '0;
                        n_depth = '0;
                        n_cnt   = '0;
                        n_q.hit = 1'b1;
                    end
                end
                tlct_pkg::MODE_CLEAR_FROM: begin
                    if (!empty && (r_depth >= i_q.depth)) begin
                        n_key   = '0;
                        n_depth = '0;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    n_key   = '0;
                    n_depth = '0;
                    n_cnt   = '0;
                end
            endcase
        end
        if (i_wr.vld && (i_wr.idx == i_idx)) begin
            n_key   = i_wr.key;
            n_depth = i_wr.depth;
            n_cnt   = i_wr.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_depth <= '0;
            r_cnt   <= '0;
            r_q     <= '0;
        end else begin
            r_key   <= n_key;
            r_depth <= n_depth;
            r_cnt   <= n_cnt;
            r_q     <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== design/tagged_loop_counter_table_unit.sv =====
// ----------------------------------------------------------------------------
// tagged_loop_counter_table_unit
// Table of tagged loop counters built as a row of slot cells; a query word
// walks the row one cell per cycle and a new slot is claimed at the end.
//
//   port    dir  words                                   handshake
//   i_in    in   mode, key, nest_depth, times            valid/ready
//   o_out   out  enter, found, table_full                valid/ready
//
// An item passes through the head register, each cell of the row, the
// result holding register and the output register, in that order; the
// last step waits while the output register holds an unaccepted result.
// A new word is taken once the previous result has left the holding
// register, so one item walks the row at a time; the output register lets
// the next item run while a result waits.
// Reset is synchronous and empties every slot.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_loop_counter_table_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tlct_in_if.sink   i_in,
    tlct_out_if.source o_out
);

    localparam int N = tlct_pkg::TABLE_ENTRIES;

    tlct_pkg::t_query  w_q [0:N];
    tlct_pkg::t_query  r_head;
    tlct_pkg::t_query  tail;
    tlct_pkg::t_commit wr;

    logic r_busy;
    logic r_pend_vld;
    logic r_pend_enter, r_pend_found, r_pend_full;
    logic r_out_vld;
    logic r_out_enter, r_out_found, r_out_full;

    logic accept;
    logic move;
    logic new_slot;
    logic res_enter, res_found, res_full;
    logic signed [tlct_pkg::COUNT_W-1:0] dec;
    logic [N:0] stage_vld;

    assign i_in.ready = !r_busy;
    assign accept     = i_in.valid && !r_busy;
    assign move       = r_pend_vld && (!r_out_vld || o_out.ready);

    assign w_q[0] = r_head;
    assign tail   = w_q[N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        tlct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (tlct_pkg::IDX_W'(g)),
            .i_q     (w_q[g]),
            .i_wr    (wr),
            .o_q     (w_q[g+1])
        );
        assign stage_vld[g+1] = w_q[g+1].vld;
    end
    assign stage_vld[0] = r_head.vld;

    always_comb begin
        dec      = tlct_pkg::sat_dec(tail.times);
        new_slot = tail.vld && (tail.mode == tlct_pkg::MODE_REPEAT)
                   && (tail.key != '0) && !tail.hit;
        wr.vld   = new_slot && tail.have_empty;
        wr.idx   = tail.empty_idx;
        wr.key   = tail.key;
        wr.depth = tail.depth;
        wr.count = dec;
        res_found = tail.hit;
        res_full  = new_slot && !tail.have_empty;
        res_enter = tail.hit ? tail.enter : (wr.vld && !dec[tlct_pkg::COUNT_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_busy     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_head.vld        <= accept;
            r_head.mode       <= i_in.mode;
            r_head.key        <= i_in.key[tlct_pkg::SKEY_W-1:0];
            r_head.depth      <= i_in.nest_depth;
            r_head.times      <= i_in.times;
            r_head.hit        <= 1'b0;
            r_head.enter      <= 1'b0;
            r_head.have_empty <= 1'b0;
            r_head.empty_idx  <= '0;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            if (tail.vld) begin
                r_pend_vld <= 1'b1;
            end else if (move) begin
                r_pend_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.vld) begin
            r_pend_enter <= res_enter;
            r_pend_found <= res_found;
            r_pend_full  <= res_full;
        end
        if (move) begin
            r_out_enter <= r_pend_enter;
            r_out_found <= r_pend_found;
            r_out_full  <= r_pend_full;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.enter      = r_out_enter;
    assign o_out.found      = r_out_found;
    assign o_out.table_full = r_out_full;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({stage_vld, r_pend_vld}))
        else $error("more than one query in the cell row");

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.vld |-> r_busy)
        else $error("query reached row end while idle");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> r_busy)
        else $error("held result without an item in flight");

    a_claim_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.vld |-> !res_full && !res_found)
        else $error("slot claim together with hit or full");

endmodule

`default_nettype wire
